### hw/rtl/tmfp_pkg.sv
// ----------------------------------------------------------------------------
// tmfp_pkg
// Shared types and codes for the tagged message frame parser.
// ----------------------------------------------------------------------------
package tmfp_pkg;

    localparam int unsigned DATA_W      = 8;
    localparam int unsigned LEN_W       = 15;
    localparam int unsigned TAG_W       = 2;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned ERR_W       = 3;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned OUT_TUSER_W = KIND_W + TAG_W;

    localparam int unsigned MIN_FRAME   = 9;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0] POS_MAX = {LEN_W{1'b1}};

    // result kinds
    localparam logic [KIND_W-1:0] KIND_BODY     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_VERSION   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_SHORT_LEN = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_TAG   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OVERRUN   = 3'd4;

    // field tag limit and version bytes
    localparam logic [DATA_W-1:0] TAG_MAX     = 8'd2;
    localparam logic [DATA_W-1:0] VERSION_HI  = 8'd1;
    localparam logic [DATA_W-1:0] VERSION_LO  = 8'd0;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [DATA_W-1:0] body;
        logic              field_last;
        logic [ERR_W-1:0]  err;
        logic              last;
    } result_t;

    // two base-127 digits: hi * 127 + lo
    function automatic logic [LEN_W-1:0] base127(input logic [DATA_W-1:0] hi,
                                                 input logic [DATA_W-1:0] lo);
        logic [LEN_W-1:0] hi_w;
        hi_w = LEN_W'(hi);
        return (hi_w << 7) - hi_w + LEN_W'(lo);
    endfunction

endpackage

### hw/rtl/tagged_message_frame_parser.sv
// ----------------------------------------------------------------------------
// tagged_message_frame_parser
// Byte-stream deframer for tagged messages with base-127 length digits.
// ----------------------------------------------------------------------------
// One input word is one byte; a new byte is taken every cycle while the
// four-entry result queue has room for two results. A byte yields zero, one
// or two results (a body byte, then a completion or error marker), so the
// parser runs at one byte per cycle whenever the sink keeps up with one result
// per cycle; a two-result byte can make the parser wait for the sink.
// Each result is written into the result queue when its byte is accepted.
// After any error the parser swallows every byte silently until reset.
module tagged_message_frame_parser (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [tmfp_pkg::DATA_W-1:0]          s_tdata,  // [7:0] data_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] body_byte, [8] field_last, [11:9] error_code, [15:12] zero
    output logic [tmfp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [tmfp_pkg::OUT_TUSER_W-1:0]     m_tuser,  // [1:0] result_kind, [3:2] field_tag
    output logic                                 m_tlast   // last_of_step
);
    import tmfp_pkg::*;

    localparam logic [3:0] PH_VER0    = 4'd0;
    localparam logic [3:0] PH_VER1    = 4'd1;
    localparam logic [3:0] PH_LEN_HI  = 4'd2;
    localparam logic [3:0] PH_LEN_LO  = 4'd3;
    localparam logic [3:0] PH_TAG     = 4'd4;
    localparam logic [3:0] PH_FLEN_HI = 4'd5;
    localparam logic [3:0] PH_FLEN_LO = 4'd6;
    localparam logic [3:0] PH_BODY    = 4'd7;
    localparam logic [3:0] PH_ERROR   = 4'd8;

    logic [3:0]        phase_reg,     phase_next;
    logic [LEN_W-1:0]  frame_len_reg, frame_len_next;
    logic [LEN_W-1:0]  frame_pos_reg, frame_pos_next;
    logic [DATA_W-1:0] len_hi_reg,    len_hi_next;
    logic [LEN_W-1:0]  remain_reg,    remain_next;
    logic [TAG_W-1:0]  tag_reg,       tag_next;

    result_t           queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    logic              s_accept, m_accept;
    result_t           res0, res1, bnd_res;
    logic [1:0]        res_cnt, push_cnt;
    logic [LEN_W-1:0]  pos_adv, flen, remain_dec;
    logic              bnd_emit;
    logic [3:0]        bnd_phase;
    logic [LEN_W-1:0]  bnd_pos;
    result_t           head;

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign s_tready = count_reg <= QCNT_W'(QUEUE_DEPTH - 2);

    assign pos_adv    = (frame_pos_reg == POS_MAX) ? frame_pos_reg : frame_pos_reg + 1'b1;
    assign flen       = base127(len_hi_reg, s_tdata);
    assign remain_dec = remain_reg - 1'b1;

    // field boundary check, always against the advanced position
    always_comb
    begin
        bnd_res   = '0;
        bnd_emit  = 1'b0;
        bnd_phase = PH_TAG;
        bnd_pos   = pos_adv;
        priority if (pos_adv == frame_len_reg)
        begin
            bnd_emit      = 1'b1;
            bnd_res.kind  = KIND_COMPLETE;
            bnd_phase     = PH_VER0;
            bnd_pos       = '0;
        end
        else if (pos_adv > frame_len_reg)
        begin
            bnd_emit      = 1'b1;
            bnd_res.kind  = KIND_ERROR;
            bnd_res.err   = ERR_OVERRUN;
            bnd_phase     = PH_ERROR;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        frame_len_next = frame_len_reg;
        frame_pos_next = frame_pos_reg;
        len_hi_next    = len_hi_reg;
        remain_next    = remain_reg;
        tag_next       = tag_reg;
        res0           = '0;
        res1           = '0;
        res_cnt        = 2'd0;

        unique case (phase_reg)
            PH_VER0:
            begin
                if (s_tdata != VERSION_HI)
                begin
                    res0.kind  = KIND_ERROR;
                    res0.err   = ERR_VERSION;
                    res_cnt    = 2'd1;
                    phase_next = PH_ERROR;
                end
                else
                    phase_next = PH_VER1;
            end
            PH_VER1:
            begin
                if (s_tdata != VERSION_LO)
                begin
                    res0.kind  = KIND_ERROR;
                    res0.err   = ERR_VERSION;
                    res_cnt    = 2'd1;
                    phase_next = PH_ERROR;
                end
                else
                    phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_hi_next = s_tdata;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                frame_len_next = flen;
                frame_pos_next = '0;
                if (flen < LEN_W'(MIN_FRAME))
                begin
                    res0.kind  = KIND_ERROR;
                    res0.err   = ERR_SHORT_LEN;
                    res_cnt    = 2'd1;
                    phase_next = PH_ERROR;
                end
                else
                    phase_next = PH_TAG;
            end
            PH_TAG:
            begin
                frame_pos_next = pos_adv;
                if (s_tdata > TAG_MAX)
                begin
                    res0.kind  = KIND_ERROR;
                    res0.err   = ERR_BAD_TAG;
                    res_cnt    = 2'd1;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    tag_next   = s_tdata[TAG_W-1:0];
                    phase_next = PH_FLEN_HI;
                end
            end
            PH_FLEN_HI:
            begin
                frame_pos_next = pos_adv;
                len_hi_next    = s_tdata;
                phase_next     = PH_FLEN_LO;
            end
            PH_FLEN_LO:
            begin
                frame_pos_next = pos_adv;
                remain_next    = flen;
                if (flen == '0)
                begin
                    // empty field: boundary straight after the length digits
                    res0           = bnd_res;
                    res_cnt        = {1'b0, bnd_emit};
                    phase_next     = bnd_phase;
                    frame_pos_next = bnd_pos;
                end
                else
                    phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                frame_pos_next  = pos_adv;
                remain_next     = remain_dec;
                res0.kind       = KIND_BODY;
                res0.tag        = tag_reg;
                res0.body       = s_tdata;
                res0.field_last = (remain_dec == '0);
                res_cnt         = 2'd1;
                if (remain_dec == '0)
                begin
                    res1           = bnd_res;
                    res_cnt        = bnd_emit ? 2'd2 : 2'd1;
                    phase_next     = bnd_phase;
                    frame_pos_next = bnd_pos;
                end
            end
            PH_ERROR:
                phase_next = PH_ERROR;
            default:
                phase_next = PH_ERROR;
        endcase

        // mark the final result of this byte
        unique case (res_cnt)
            2'd1:    res0.last = 1'b1;
            2'd2:    res1.last = 1'b1;
            default: ;
        endcase
    end

    assign push_cnt = s_accept ? res_cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_VER0;
            frame_len_reg <= '0;
            frame_pos_reg <= '0;
            len_hi_reg    <= '0;
            remain_reg    <= '0;
            tag_reg       <= '0;
        end
        else if (s_accept)
        begin
            phase_reg     <= phase_next;
            frame_len_reg <= frame_len_next;
            frame_pos_reg <= frame_pos_next;
            len_hi_reg    <= len_hi_next;
            remain_reg    <= remain_next;
            tag_reg       <= tag_next;
        end
    end

    // result queue: up to two writes, one read per cycle
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (push_cnt == 2'd2)
            queue_reg[wr_ptr_reg + 1'b1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_cnt);
            if (m_accept)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + QCNT_W'(push_cnt) - QCNT_W'(m_accept);
        end
    end

    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {4'd0, head.err, head.field_last, head.body};
    assign m_tuser  = {head.tag, head.kind};
    assign m_tlast  = head.last;

    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |=> phase_reg == PH_ERROR)
        else $error("parser left error state without reset");

    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |-> push_cnt == 2'd0)
        else $error("result produced after error");

    a_body_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[KIND_W-1:0] == KIND_BODY |-> m_tdata[11:9] == ERR_NONE)
        else $error("body result carries an error code");

endmodule
